[src/rwdr_pkg.sv]
// Shared types, constants and calendar tables for the rule weekday date resolver.
package rwdr_pkg;

   localparam logic [14:0] YEAR_OFFSET = 15'd400;
   // 2^16/25 rounded up; exact floor(x/25) for x below 4196
   localparam logic [11:0] RECIP_25 = 12'd2622;
   localparam logic [12:0] DIV_25 = 13'd25;
   localparam logic [4:0] WEEK_SPAN = 5'd6;
   localparam logic [3:0] DAYS_PER_WEEK = 4'd7;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_MAR = 4'd3;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic signed [1:0] STEP_NONE = 2'sd0;
   localparam logic signed [1:0] STEP_UP = 2'sd1;
   localparam logic signed [1:0] STEP_DOWN = -2'sd1;

   typedef enum logic [1:0] {
      MODE_EXACT,
      MODE_AFTER,
      MODE_BEFORE
   } mode_type;

   typedef struct packed {
      logic [3:0]        month;
      logic [2:0]        want;
      logic signed [5:0] anchor;
   } ctx_type;

   // days in month m (1..12), February by leap flag
   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      case (m)
         4'd2:    d = leap ? 5'd29 : 5'd28;
         4'd4:    d = 5'd30;
         4'd6:    d = 5'd30;
         4'd9:    d = 5'd30;
         4'd11:   d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

   // (13*(m'+1))/5 mod 7 with January and February counted as months 13 and 14
   function automatic logic [2:0] month_term(input logic [3:0] m);
      logic [2:0] t;
      case (m)
         4'd1:    t = 3'd1;
         4'd2:    t = 3'd4;
         4'd3:    t = 3'd3;
         4'd4:    t = 3'd6;
         4'd5:    t = 3'd1;
         4'd6:    t = 3'd4;
         4'd7:    t = 3'd6;
         4'd8:    t = 3'd2;
         4'd9:    t = 3'd5;
         4'd10:   t = 3'd0;
         4'd11:   t = 3'd3;
         default: t = 3'd5;
      endcase
      return t;
   endfunction

   // mod 7 by folding octal digits (8 = 1 mod 7)
   function automatic logic [2:0] mod7(input logic [15:0] x);
      logic [5:0] s1;
      logic [3:0] s2;
      s1 = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]} + {3'd0, x[11:9]}
         + {3'd0, x[14:12]} + {5'd0, x[15]};
      s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
      if (s2 >= DAYS_PER_WEEK) begin
         s2 = s2 - DAYS_PER_WEEK;
      end
      return s2[2:0];
   endfunction

   // Zeller residue to ISO weekday, 1 Monday .. 7 Sunday
   function automatic logic [2:0] iso_weekday(input logic [2:0] h);
      logic [2:0] d;
      if (h < 3'd2) begin
         d = h + 3'd6;
      end else begin
         d = h - 3'd1;
      end
      return d;
   endfunction

endpackage

[src/rwdr_decode.sv]
// Input stage: month saturation and year offsets for leap and weekday arithmetic.
module rwdr_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  in_valid,
   input  logic [13:0]           year,
   input  logic [3:0]            month,
   input  logic [2:0]            want,
   input  logic signed [5:0]     anchor,
   output logic                  out_valid,
   output logic [14:0]           yy,
   output logic [14:0]           dy,
   output rwdr_pkg::ctx_type     ctx
);
   import rwdr_pkg::*;

   logic       valid_ff;
   logic [14:0] yy_ff, yy_in;
   logic [14:0] dy_ff, dy_in;
   ctx_type     ctx_ff, ctx_in;
   logic [3:0]  m_sat;

   always_comb begin
      if (month < MONTH_JAN) begin
         m_sat = MONTH_JAN;
      end else if (month > MONTH_DEC) begin
         m_sat = MONTH_DEC;
      end else begin
         m_sat = month;
      end
      yy_in = {1'b0, year} + YEAR_OFFSET;
      dy_in = yy_in - {14'd0, (m_sat < MONTH_MAR)};
      ctx_in.month = m_sat;
      ctx_in.want = want;
      ctx_in.anchor = anchor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         yy_ff <= yy_in;
         dy_ff <= dy_in;
         ctx_ff <= ctx_in;
      end
   end

   assign out_valid = valid_ff;
   assign yy = yy_ff;
   assign dy = dy_ff;
   assign ctx = ctx_ff;

endmodule

[src/rwdr_year_unit.sv]
// Two stages: reciprocal divisions by 25, then year weekday residue, leap flag, month length.
module rwdr_year_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_b,
   input  logic                  load_c,
   input  logic                  in_valid,
   input  logic [14:0]           yy,
   input  logic [14:0]           dy,
   input  rwdr_pkg::ctx_type     ctx,
   output logic                  valid_b,
   output logic                  out_valid,
   output logic [2:0]            base,
   output logic                  leap,
   output logic [4:0]            dim,
   output rwdr_pkg::ctx_type     out_ctx
);
   import rwdr_pkg::*;

   // stage B
   logic        vb_ff;
   logic [24:0] p_dow_ff, p_dow_in;
   logic [24:0] p_leap_ff, p_leap_in;
   logic [14:0] s_ff, s_in;
   logic [12:0] k2_ff;
   logic [1:0]  yy_lo_ff;
   ctx_type     ctx_b_ff;

   // stage C
   logic        vc_ff;
   logic [2:0]  base_ff, base_in;
   logic        leap_ff, leap_in;
   logic [4:0]  dim_ff, dim_in;
   ctx_type     ctx_c_ff;

   logic [7:0]  q1, q2;
   logic [15:0] term;
   logic [2:0]  ymod;
   logic [3:0]  sumb;
   logic [12:0] prod25;

   always_comb begin
      p_dow_in = {12'd0, dy[14:2]} * {13'd0, RECIP_25};
      p_leap_in = {12'd0, yy[14:2]} * {13'd0, RECIP_25};
      s_in = dy + {2'b00, dy[14:2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (load_b) begin
         vb_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_b) begin
         p_dow_ff <= p_dow_in;
         p_leap_ff <= p_leap_in;
         s_ff <= s_in;
         k2_ff <= yy[14:2];
         yy_lo_ff <= yy[1:0];
         ctx_b_ff <= ctx;
      end
   end

   always_comb begin
      q1 = p_dow_ff[23:16];
      q2 = p_leap_ff[23:16];
      term = {1'b0, s_ff} - {8'd0, q1} + {10'd0, q1[7:2]};
      ymod = mod7(term);
      sumb = {1'b0, ymod} + {1'b0, month_term(ctx_b_ff.month)};
      if (sumb >= DAYS_PER_WEEK) begin
         sumb = sumb - DAYS_PER_WEEK;
      end
      base_in = sumb[2:0];
      prod25 = {5'd0, q2} * DIV_25;
      leap_in = (yy_lo_ff == 2'd0) && ((k2_ff != prod25) || (q2[1:0] == 2'd0));
      dim_in = month_days(ctx_b_ff.month, leap_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (load_c) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_c) begin
         base_ff <= base_in;
         leap_ff <= leap_in;
         dim_ff <= dim_in;
         ctx_c_ff <= ctx_b_ff;
      end
   end

   assign valid_b = vb_ff;
   assign out_valid = vc_ff;
   assign base = base_ff;
   assign leap = leap_ff;
   assign dim = dim_ff;
   assign out_ctx = ctx_c_ff;

endmodule

[src/rwdr_day_select.sv]
// Stage D: start day, weekday of the start day and shift to the wanted weekday.
module rwdr_day_select (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  in_valid,
   input  logic [2:0]            base,
   input  logic                  leap,
   input  logic [4:0]            dim,
   input  rwdr_pkg::ctx_type     ctx,
   output logic                  out_valid,
   output rwdr_pkg::mode_type    mode,
   output logic signed [6:0]     cand,
   output logic [4:0]            exact_day,
   output logic [4:0]            out_dim,
   output logic                  out_leap,
   output logic [3:0]            month
);
   import rwdr_pkg::*;

   logic              valid_ff;
   mode_type          mode_ff, mode_in;
   logic signed [6:0] cand_ff, cand_in;
   logic [4:0]        exact_ff, exact_in;
   logic [4:0]        dim_ff;
   logic              leap_ff;
   logic [3:0]        month_ff;

   logic [5:0] mag;
   logic [4:0] sat_day;
   logic [4:0] on;
   logic [5:0] hsum;
   logic [2:0] dow;
   logic [3:0] fwd, bwd;
   logic [2:0] shift_fwd, shift_bwd;

   always_comb begin
      mag = 6'd0 - ctx.anchor;
      sat_day = mag[5] ? 5'd31 : mag[4:0];
      if (ctx.anchor[5]) begin
         on = sat_day;
         exact_in = sat_day;
      end else if (ctx.anchor == 6'sd0) begin
         on = dim - WEEK_SPAN;
         exact_in = dim;
      end else begin
         on = ctx.anchor[4:0];
         exact_in = ctx.anchor[4:0];
      end
      hsum = {1'b0, on} + {3'd0, base};
      dow = iso_weekday(mod7({10'd0, hsum}));
      fwd = {1'b0, ctx.want} + DAYS_PER_WEEK - {1'b0, dow};
      bwd = {1'b0, dow} + DAYS_PER_WEEK - {1'b0, ctx.want};
      if (fwd >= DAYS_PER_WEEK) begin
         fwd = fwd - DAYS_PER_WEEK;
      end
      if (bwd >= DAYS_PER_WEEK) begin
         bwd = bwd - DAYS_PER_WEEK;
      end
      shift_fwd = fwd[2:0];
      shift_bwd = bwd[2:0];
      if (ctx.want == 3'd0) begin
         mode_in = MODE_EXACT;
         cand_in = $signed({2'b00, on});
      end else if (ctx.anchor[5]) begin
         mode_in = MODE_BEFORE;
         cand_in = $signed({2'b00, on}) - $signed({4'd0, shift_bwd});
      end else begin
         mode_in = MODE_AFTER;
         cand_in = $signed({2'b00, on}) + $signed({4'd0, shift_fwd});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mode_ff <= mode_in;
         cand_ff <= cand_in;
         exact_ff <= exact_in;
         dim_ff <= dim;
         leap_ff <= leap;
         month_ff <= ctx.month;
      end
   end

   assign out_valid = valid_ff;
   assign mode = mode_ff;
   assign cand = cand_ff;
   assign exact_day = exact_ff;
   assign out_dim = dim_ff;
   assign out_leap = leap_ff;
   assign month = month_ff;

endmodule

[src/rwdr_rollover.sv]
// Output stage: month and year rollover of the selected day, result register.
module rwdr_rollover (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  in_valid,
   input  rwdr_pkg::mode_type    mode,
   input  logic signed [6:0]     cand,
   input  logic [4:0]            exact_day,
   input  logic [4:0]            dim,
   input  logic                  leap,
   input  logic [3:0]            month,
   output logic                  out_valid,
   output logic [3:0]            result_month,
   output logic [4:0]            result_day,
   output logic signed [1:0]     year_step
);
   import rwdr_pkg::*;

   logic              valid_ff;
   logic [3:0]        month_ff, month_in;
   logic [4:0]        day_ff, day_in;
   logic signed [1:0] step_ff, step_in;

   logic [3:0]        prev;
   logic signed [6:0] over, under;

   always_comb begin
      month_in = month;
      step_in = STEP_NONE;
      day_in = cand[4:0];
      prev = (month == MONTH_JAN) ? MONTH_DEC : (month - 4'd1);
      over = cand - $signed({2'b00, dim});
      under = cand + $signed({2'b00, month_days(prev, leap)});
      case (mode)
         MODE_EXACT: begin
            day_in = exact_day;
         end
         MODE_AFTER: begin
            if (cand > $signed({2'b00, dim})) begin
               day_in = over[4:0];
               if (month == MONTH_DEC) begin
                  month_in = MONTH_JAN;
                  step_in = STEP_UP;
               end else begin
                  month_in = month + 4'd1;
               end
            end
         end
         MODE_BEFORE: begin
            if (cand < 7'sd1) begin
               day_in = under[4:0];
               month_in = prev;
               if (month == MONTH_JAN) begin
                  step_in = STEP_DOWN;
               end
            end
         end
         default: begin
            day_in = exact_day;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         month_ff <= month_in;
         day_ff <= day_in;
         step_ff <= step_in;
      end
   end

   assign out_valid = valid_ff;
   assign result_month = month_ff;
   assign result_day = day_ff;
   assign year_step = step_ff;

endmodule

[src/rule_weekday_date_resolver.sv]
// Top level of the rule weekday date resolver: five-stage pipeline and stall chain.
// Resolves a daylight-saving rule (year, month, ISO weekday, anchor day) to a month, day and
// year step. Fully pipelined over five register stages: input decode, division of the year
// by 25 through reciprocal multiplication, year weekday residue and month length, weekday
// shift, then rollover into the output register. One item is taken every cycle while req_stall is
// low. Each full stage holds while the one after it is full and stalled, so empty stages fill
// up before req_stall is raised. Reset clears only the valids.
module rule_weekday_date_resolver (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [13:0]       req_year,
   input  logic [3:0]        req_month,
   input  logic [2:0]        req_weekday_wanted,
   input  logic signed [5:0] req_anchor_day,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_result_month,
   output logic [4:0]        rsp_result_day,
   output logic signed [1:0] rsp_year_step
);
   import rwdr_pkg::*;

   logic        va, vb, vc, vd;
   logic        load_a, load_b, load_c, load_d, load_e;
   logic [14:0] yy_a, dy_a;
   ctx_type     ctx_a, ctx_c;
   logic [2:0]  base_c;
   logic        leap_c, leap_d;
   logic [4:0]  dim_c, dim_d;
   mode_type    mode_d;
   logic signed [6:0] cand_d;
   logic [4:0]  exact_d;
   logic [3:0]  month_d;

   assign load_e = !rsp_valid || !rsp_stall;
   assign load_d = !vd || load_e;
   assign load_c = !vc || load_d;
   assign load_b = !vb || load_c;
   assign load_a = !va || load_b;
   assign req_stall = !load_a;

   rwdr_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .load      (load_a),
      .in_valid  (req_valid),
      .year      (req_year),
      .month     (req_month),
      .want      (req_weekday_wanted),
      .anchor    (req_anchor_day),
      .out_valid (va),
      .yy        (yy_a),
      .dy        (dy_a),
      .ctx       (ctx_a)
   );

   rwdr_year_unit u_year (
      .clock     (clock),
      .reset     (reset),
      .load_b    (load_b),
      .load_c    (load_c),
      .in_valid  (va),
      .yy        (yy_a),
      .dy        (dy_a),
      .ctx       (ctx_a),
      .valid_b   (vb),
      .out_valid (vc),
      .base      (base_c),
      .leap      (leap_c),
      .dim       (dim_c),
      .out_ctx   (ctx_c)
   );

   rwdr_day_select u_day (
      .clock     (clock),
      .reset     (reset),
      .load      (load_d),
      .in_valid  (vc),
      .base      (base_c),
      .leap      (leap_c),
      .dim       (dim_c),
      .ctx       (ctx_c),
      .out_valid (vd),
      .mode      (mode_d),
      .cand      (cand_d),
      .exact_day (exact_d),
      .out_dim   (dim_d),
      .out_leap  (leap_d),
      .month     (month_d)
   );

   rwdr_rollover u_roll (
      .clock        (clock),
      .reset        (reset),
      .load         (load_e),
      .in_valid     (vd),
      .mode         (mode_d),
      .cand         (cand_d),
      .exact_day    (exact_d),
      .dim          (dim_d),
      .leap         (leap_d),
      .month        (month_d),
      .out_valid    (rsp_valid),
      .result_month (rsp_result_month),
      .result_day   (rsp_result_day),
      .year_step    (rsp_year_step)
   );

endmodule

[verif/tb_rule_weekday_date_resolver.sv]
// Self-checking testbench for the rule weekday date resolver: directed and random rule queries.
module tb_rule_weekday_date_resolver;
   timeunit 1ns;
   timeprecision 1ps;

   import rwdr_pkg::*;

   typedef struct {
      logic [13:0]       year;
      logic [3:0]        month;
      logic [2:0]        want;
      logic signed [5:0] anchor;
   } rule_query_type;

   typedef struct {
      logic [3:0]        month;
      logic [4:0]        day;
      logic signed [1:0] step;
   } rule_date_type;

   typedef struct {
      rule_query_type query;
      rule_date_type  date;
   } date_expect_type;

   localparam int RANDOM_QUERIES = 1050;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [13:0]       req_year = '0;
   logic [3:0]        req_month = '0;
   logic [2:0]        req_weekday_wanted = '0;
   logic signed [5:0] req_anchor_day = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [3:0]        rsp_result_month;
   logic [4:0]        rsp_result_day;
   logic signed [1:0] rsp_year_step;

   rule_query_type  pending_queries[$];
   date_expect_type expected_dates[$];
   int              error_count = 0;
   int              gap_left = 0;
   int              stall_left = 0;
   int              sent_count = 0;
   int              taken_count = 0;

   rule_weekday_date_resolver dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_year           (req_year),
      .req_month          (req_month),
      .req_weekday_wanted (req_weekday_wanted),
      .req_anchor_day     (req_anchor_day),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_month   (rsp_result_month),
      .rsp_result_day     (rsp_result_day),
      .rsp_year_step      (rsp_year_step)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit year_is_leap(input int unsigned yy);
      return ((yy % 4) == 0 && (yy % 100) != 0) || (yy % 400) == 0;
   endfunction

   function automatic int unsigned month_length(input int unsigned yy, input int unsigned m);
      case (m)
         2:       return year_is_leap(yy) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   // ISO weekday; keeps counting past the month end
   function automatic int unsigned weekday_of(input int unsigned yy, input int unsigned m,
                                              input int unsigned d);
      int unsigned h;
      if (m < 3) begin
         yy = yy - 1;
         m = m + 12;
      end
      h = (d + (13 * (m + 1)) / 5 + yy + yy / 4 - yy / 100 + yy / 400) % 7;
      return ((h + 5) % 7) + 1;
   endfunction

   function automatic rule_date_type resolve_rule_date(input rule_query_type q);
      int unsigned       yy;
      int unsigned       m;
      int unsigned       want;
      int                anchor;
      int unsigned       day;
      int unsigned       dim;
      int unsigned       on;
      int unsigned       shift;
      int                sday;
      logic signed [1:0] step;
      rule_date_type     r;
      yy = int'(q.year) + 400;
      m = q.month;
      want = q.want;
      anchor = q.anchor;
      step = STEP_NONE;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      if (want == 0) begin
         if (anchor > 0) begin
            day = anchor;
         end else if (anchor == 0) begin
            day = month_length(yy, m);
         end else begin
            day = -anchor;
            if (day > 31) day = 31;
         end
      end else if (anchor >= 0) begin
         dim = month_length(yy, m);
         on = (anchor == 0) ? dim - 6 : anchor;
         shift = (want + 7 - weekday_of(yy, m, on)) % 7;
         day = on + shift;
         if (day > dim) begin
            day = day - dim;
            m = m + 1;
            if (m > 12) begin
               m = 1;
               step = STEP_UP;
            end
         end
      end else begin
         on = -anchor;
         if (on > 31) on = 31;
         shift = (weekday_of(yy, m, on) + 7 - want) % 7;
         sday = int'(on) - int'(shift);
         if (sday < 1) begin
            if (m == 1) begin
               m = 12;
               step = STEP_DOWN;
               yy = yy - 1;
            end else begin
               m = m - 1;
            end
            sday = sday + int'(month_length(yy, m));
         end
         day = sday;
      end
      r.month = m[3:0];
      r.day = day[4:0];
      r.step = step;
      return r;
   endfunction

   // quiet stretch every fourth block of 100 items
   function automatic int draw_wait(input int n);
      return ((n / 100) % 4 == 3) ? 0 : $urandom_range(0, 4);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH: %s", msg);
   endtask

   task automatic add_query(input int year, input int month, input int want, input int anchor);
      rule_query_type q;
      q.year = 14'(year);
      q.month = 4'(month);
      q.want = 3'(want);
      q.anchor = 6'(anchor);
      pending_queries.push_back(q);
   endtask

   always @(posedge clock) begin : drive_items
      rule_query_type  q;
      date_expect_type e;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            e.query.year = req_year;
            e.query.month = req_month;
            e.query.want = req_weekday_wanted;
            e.query.anchor = req_anchor_day;
            e.date = resolve_rule_date(e.query);
            expected_dates.push_back(e);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left == 0 && pending_queries.size() > 0) begin
               q = pending_queries.pop_front();
               req_year <= q.year;
               req_month <= q.month;
               req_weekday_wanted <= q.want;
               req_anchor_day <= q.anchor;
               req_valid <= 1'b1;
               gap_left <= draw_wait(sent_count);
               sent_count <= sent_count + 1;
            end else begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left <= gap_left - 1;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      date_expect_type e;
      int              hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         hold = stall_left;
         if (rsp_valid && !rsp_stall) begin
            if (expected_dates.size() == 0) begin
               report_mismatch($sformatf("unexpected item month %0d day %0d step %0d",
                                         rsp_result_month, rsp_result_day, rsp_year_step));
            end else begin
               e = expected_dates.pop_front();
               if (rsp_result_month !== e.date.month)
                  report_mismatch($sformatf("month got %0d exp %0d (y %0d m %0d w %0d a %0d)",
                     rsp_result_month, e.date.month, e.query.year, e.query.month,
                     e.query.want, e.query.anchor));
               if (rsp_result_day !== e.date.day)
                  report_mismatch($sformatf("day got %0d exp %0d (y %0d m %0d w %0d a %0d)",
                     rsp_result_day, e.date.day, e.query.year, e.query.month,
                     e.query.want, e.query.anchor));
               if (rsp_year_step !== e.date.step)
                  report_mismatch($sformatf("step got %0d exp %0d (y %0d m %0d w %0d a %0d)",
                     rsp_year_step, e.date.step, e.query.year, e.query.month,
                     e.query.want, e.query.anchor));
            end
            hold = draw_wait(taken_count);
            taken_count <= taken_count + 1;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= hold - 1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
         end
      end
   end

   initial begin : run_test
      int r;
      int year;
      int month;
      int want;
      int anchor;
      // directed: typical rules, leap years, saturation and year rollover
      add_query(2024, 3, 7, 0);
      add_query(2024, 10, 7, 0);
      add_query(2023, 3, 7, 8);
      add_query(2023, 11, 7, 1);
      add_query(2024, 2, 0, 0);
      add_query(1900, 2, 0, 0);
      add_query(2000, 2, 0, 0);
      add_query(2023, 4, 0, 31);
      add_query(2023, 6, 0, -15);
      add_query(2023, 6, 0, -32);
      add_query(2023, 5, 5, -32);
      add_query(2023, 12, 1, 31);
      add_query(2023, 12, 6, 0);
      add_query(2023, 1, 1, -1);
      add_query(2023, 3, 3, -1);
      add_query(2023, 2, 2, 31);
      add_query(2023, 2, 4, -31);
      add_query(0, 2, 0, 0);
      add_query(16383, 2, 7, 0);
      add_query(9999, 12, 7, 31);
      add_query(1, 1, 1, -1);
      add_query(2023, 0, 3, 5);
      add_query(2023, 15, 3, 5);
      add_query(2023, 13, 2, 0);
      add_query(2023, 7, 0, 1);
      for (int i = 0; i < RANDOM_QUERIES; i++) begin
         r = $urandom_range(0, 9);
         year = $urandom_range(1, 9999);
         month = $urandom_range(1, 12);
         want = $urandom_range(0, 7);
         anchor = $urandom_range(0, 62) - 31;
         if (r < 2) begin
            // steer towards month and year boundaries
            month = ($urandom_range(0, 1) != 0) ? 12 : 1;
            anchor = ($urandom_range(0, 1) != 0) ? $urandom_range(25, 31)
                                                : -$urandom_range(1, 7);
         end else if (r >= 8) begin
            year = $urandom_range(0, 16383);
            month = $urandom_range(0, 15);
            anchor = $urandom_range(0, 63) - 32;
         end
         add_query(year, month, want, anchor);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_queries.size() > 0 || req_valid || expected_dates.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #200000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

[rule_weekday_date_resolver.f]
src/rwdr_pkg.sv
src/rwdr_decode.sv
src/rwdr_year_unit.sv
src/rwdr_day_select.sv
src/rwdr_rollover.sv
src/rule_weekday_date_resolver.sv
verif/tb_rule_weekday_date_resolver.sv
